// File: hw/rtl/rx_ring_line_buffer_defines.svh
// ----------------------------------------------------------------------------
// rx_ring_line_buffer_defines: assertion macros
// Shared assertion macros for the receive ring. They compile to nothing when
// SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef RX_RING_LINE_BUFFER_DEFINES_SVH
`define RX_RING_LINE_BUFFER_DEFINES_SVH

`ifndef SYNTH

// Condition that must hold at every clock edge outside reset.
`define RRLB_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("rrlb invariant violated");

// Consequent that must hold in the same cycle as the antecedent.
`define RRLB_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rrlb implication violated");

`else

`define RRLB_ASSERT_ALWAYS(label, clk, rst, cond)
`define RRLB_ASSERT_IMPLY(label, clk, rst, ante, cons)

`endif

`endif

// File: hw/rtl/rrlb_pkg.sv
// ----------------------------------------------------------------------------
// rrlb_pkg: shared types and constants of the receive ring
// Operation codes, the command and result records and the terminator test.
// ----------------------------------------------------------------------------
package rrlb_pkg;

   localparam int FUNC_W = 3;
   localparam int DATA_W = 8;
   localparam int LIM_W  = 7;

   // Operation codes; the first five match the request encoding.
   localparam logic [FUNC_W-1:0] FUNC_PUSH      = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_PEEK      = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_POP       = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_HAS_LINE  = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_READ_LINE = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_NOP       = 3'd5;

   // Longest line that one read may return.
   localparam logic [LIM_W-1:0] MAX_LINE = 7'd64;

   // Line terminators.
   localparam logic [DATA_W-1:0] CH_CR = 8'h0D;
   localparam logic [DATA_W-1:0] CH_LF = 8'h0A;

   // Command queue between the front end and the engine.
   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

   typedef struct packed {
      logic [FUNC_W-1:0] op;
      logic [DATA_W-1:0] data;
      logic [LIM_W-1:0]  lim;
   } cmd_type;

   typedef struct packed {
      logic [DATA_W-1:0] data;
      logic              byte_valid;
      logic              line_found;
      logic              dropped;
      logic              last;
   } rsp_type;

   function automatic logic is_term(input logic [DATA_W-1:0] c);
      is_term = (c == CH_CR) || (c == CH_LF);
   endfunction

endpackage

// File: hw/rtl/rrlb_front.sv
// ----------------------------------------------------------------------------
// rrlb_front: request decoder
// Takes request transfers, maps unused function codes to a no-op and clamps
// the line limit before handing the command to the queue.
// ----------------------------------------------------------------------------
module rrlb_front (
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [15:0]         req_tdata,
   input  logic [2:0]          req_tuser,
   output logic                cmd_valid,
   input  logic                cmd_ready,
   output rrlb_pkg::cmd_type   cmd
);

   logic [rrlb_pkg::LIM_W-1:0] raw_lim;

   // The queue's free space paces the request side.
   assign req_tready = cmd_ready;
   assign cmd_valid  = req_tvalid;
   assign raw_lim    = req_tdata[14:8];

   // Classify the function code and clamp the limit.
   always_comb begin
      cmd.data = req_tdata[7:0];
      cmd.lim  = (raw_lim > rrlb_pkg::MAX_LINE) ? rrlb_pkg::MAX_LINE : raw_lim;
      if (req_tuser > rrlb_pkg::FUNC_READ_LINE) begin
         cmd.op = rrlb_pkg::FUNC_NOP;
      end else begin
         cmd.op = req_tuser;
      end
   end

endmodule

// File: hw/rtl/rrlb_cmdq.sv
// ----------------------------------------------------------------------------
// rrlb_cmdq: command queue
// A short first-in first-out queue that decouples the request decoder from
// the ring engine.
// ----------------------------------------------------------------------------
`include "rx_ring_line_buffer_defines.svh"

module rrlb_cmdq (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  rrlb_pkg::cmd_type push_cmd,
   output logic              pop_valid,
   input  logic              pop_ready,
   output rrlb_pkg::cmd_type pop_cmd
);

   rrlb_pkg::cmd_type                 entry_ff [rrlb_pkg::CMDQ_DEPTH];
   logic [rrlb_pkg::CMDQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [rrlb_pkg::CMDQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [rrlb_pkg::CMDQ_CNT_W-1:0]   count_ff, count_in;
   logic                              do_push, do_pop;

   assign push_ready = (count_ff != rrlb_pkg::CMDQ_CNT_W'(rrlb_pkg::CMDQ_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and occupancy update; the depth is a power of two so the
   // pointers wrap on their own.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `RRLB_ASSERT_ALWAYS(a_cmdq_count_bound, clock, reset, count_ff <= rrlb_pkg::CMDQ_CNT_W'(rrlb_pkg::CMDQ_DEPTH))
   `RRLB_ASSERT_ALWAYS(a_cmdq_ptr_count, clock, reset, ((count_ff == '0) || (count_ff == rrlb_pkg::CMDQ_CNT_W'(rrlb_pkg::CMDQ_DEPTH))) == (wr_ptr_ff == rd_ptr_ff))
   `RRLB_ASSERT_IMPLY(a_cmdq_no_empty_pop, clock, reset, pop_ready, count_ff != '0 || !do_pop)

endmodule

// File: hw/rtl/rrlb_engine.sv
// ----------------------------------------------------------------------------
// rrlb_engine: ring engine
// Owns the byte ring, its indexes and a count of pending terminators, runs
// one command at a time and drives the result register.
// ----------------------------------------------------------------------------
`include "rx_ring_line_buffer_defines.svh"

module rrlb_engine #(
   parameter int RING_DEPTH = 512
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  rrlb_pkg::cmd_type cmd,
   output logic              out_valid,
   input  logic              out_ready,
   output rrlb_pkg::rsp_type out_item
);

   localparam int IDX_W = $clog2(RING_DEPTH);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_PUSH = 3'd1;
   localparam logic [2:0] S_HEAD = 3'd2;
   localparam logic [2:0] S_EMIT = 3'd3;
   localparam logic [2:0] S_LREQ = 3'd4;
   localparam logic [2:0] S_LDAT = 3'd5;
   localparam logic [2:0] S_LFIN = 3'd6;

   // Ring storage and its registered read port.
   logic [rrlb_pkg::DATA_W-1:0] ring_mem [RING_DEPTH];
   logic [rrlb_pkg::DATA_W-1:0] rd_data_ff;
   logic                        rd_en, wr_en;

   logic [2:0]                  state_ff, state_in;
   logic [IDX_W-1:0]            rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]            wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0]            cnt_ff, cnt_in;
   logic                        full_ff, full_in;
   logic                        tn_ff, tn_in;
   logic                        is_pop_ff, is_pop_in;
   logic                        em_found_ff, em_found_in;
   logic [rrlb_pkg::LIM_W-1:0]  lim_ff, lim_in;
   logic [rrlb_pkg::LIM_W-1:0]  n_ff, n_in;
   logic [rrlb_pkg::DATA_W-1:0] hold_ff, hold_in;
   logic                        hold_vld_ff, hold_vld_in;
   logic [rrlb_pkg::DATA_W-1:0] term_ff, term_in;
   logic                        seen_ff, seen_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   rrlb_pkg::rsp_type           rsp_ff, rsp_in;

   logic                        out_free;
   logic                        emit;
   rrlb_pkg::rsp_type           emit_item;
   logic                        rd_is_term;
   logic [IDX_W-1:0]            wr_next, rd_next;

   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
      ring_next = (idx == IDX_W'(RING_DEPTH - 1)) ? '0 : idx + 1'b1;
   endfunction

   assign out_free   = !rsp_valid_ff || out_ready;
   assign rd_is_term = rrlb_pkg::is_term(rd_data_ff);
   assign wr_next    = ring_next(wr_idx_ff);
   assign rd_next    = ring_next(rd_idx_ff);
   assign out_valid  = rsp_valid_ff;
   assign out_item   = rsp_ff;

   // Command sequencer.
   always_comb begin
      state_in    = state_ff;
      rd_idx_in   = rd_idx_ff;
      wr_idx_in   = wr_idx_ff;
      cnt_in      = cnt_ff;
      full_in     = full_ff;
      tn_in       = tn_ff;
      is_pop_in   = is_pop_ff;
      em_found_in = em_found_ff;
      lim_in      = lim_ff;
      n_in        = n_ff;
      hold_in     = hold_ff;
      hold_vld_in = hold_vld_ff;
      term_in     = term_ff;
      seen_in     = seen_ff;
      cmd_ready   = 1'b0;
      rd_en       = 1'b0;
      wr_en       = 1'b0;
      emit        = 1'b0;
      emit_item   = '{data: '0, byte_valid: 1'b0, line_found: 1'b0,
                      dropped: 1'b0, last: 1'b1};

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_ready   = 1'b1;
               lim_in      = cmd.lim;
               n_in        = '0;
               hold_vld_in = 1'b0;
               seen_in     = 1'b0;
               is_pop_in   = (cmd.op == rrlb_pkg::FUNC_POP);
               em_found_in = 1'b0;
               unique case (cmd.op)
                  rrlb_pkg::FUNC_PUSH: begin
                     // Write now; read the head in case it must be dropped.
                     wr_en     = 1'b1;
                     rd_en     = 1'b1;
                     wr_idx_in = wr_next;
                     full_in   = (wr_next == rd_idx_ff);
                     tn_in     = rrlb_pkg::is_term(cmd.data);
                     state_in  = S_PUSH;
                  end
                  rrlb_pkg::FUNC_PEEK, rrlb_pkg::FUNC_POP: begin
                     if (rd_idx_ff == wr_idx_ff) begin
                        state_in = S_EMIT;
                     end else begin
                        rd_en    = 1'b1;
                        state_in = S_HEAD;
                     end
                  end
                  rrlb_pkg::FUNC_HAS_LINE: begin
                     em_found_in = (cnt_ff != '0);
                     state_in    = S_EMIT;
                  end
                  rrlb_pkg::FUNC_READ_LINE: begin
                     state_in = S_LREQ;
                  end
                  default: begin
                     state_in = S_EMIT;
                  end
               endcase
            end
         end
         S_PUSH: begin
            if (out_free) begin
               emit              = 1'b1;
               emit_item.dropped = full_ff;
               cnt_in = cnt_ff + IDX_W'(tn_ff) - IDX_W'(full_ff && rd_is_term);
               if (full_ff) begin
                  rd_idx_in = rd_next;
               end
               state_in = S_IDLE;
            end
         end
         S_HEAD: begin
            if (out_free) begin
               emit                 = 1'b1;
               emit_item.data       = rd_data_ff;
               emit_item.byte_valid = 1'b1;
               if (is_pop_ff) begin
                  rd_idx_in = rd_next;
                  cnt_in    = cnt_ff - IDX_W'(rd_is_term);
               end
               state_in = S_IDLE;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               emit                 = 1'b1;
               emit_item.line_found = em_found_ff;
               state_in             = S_IDLE;
            end
         end
         S_LREQ: begin
            // Scan continues while under the limit and bytes are pending.
            if ((n_ff < lim_ff) && (rd_idx_ff != wr_idx_ff)) begin
               rd_en    = 1'b1;
               state_in = S_LDAT;
            end else begin
               state_in = S_LFIN;
            end
         end
         S_LDAT: begin
            if (out_free) begin
               if (!seen_ff) begin
                  if (!rd_is_term) begin
                     // A following ordinary byte confirms the held one.
                     if (hold_vld_ff) begin
                        emit                 = 1'b1;
                        emit_item.data       = hold_ff;
                        emit_item.byte_valid = 1'b1;
                        emit_item.last       = 1'b0;
                     end
                     hold_in     = rd_data_ff;
                     hold_vld_in = 1'b1;
                  end else begin
                     seen_in = 1'b1;
                     term_in = rd_data_ff;
                     cnt_in  = cnt_ff - 1'b1;
                  end
                  rd_idx_in = rd_next;
                  n_in      = n_ff + 1'b1;
                  state_in  = S_LREQ;
               end else if (!rd_is_term) begin
                  // Ordinary byte after a terminator stays in the ring.
                  state_in = S_LFIN;
               end else begin
                  // Terminator pair: consume both and emit neither.
                  rd_idx_in = rd_next;
                  cnt_in    = cnt_ff - 1'b1;
                  seen_in   = 1'b0;
                  state_in  = S_LFIN;
               end
            end
         end
         S_LFIN: begin
            if (out_free) begin
               emit = 1'b1;
               if (hold_vld_ff) begin
                  emit_item.data       = hold_ff;
                  emit_item.byte_valid = 1'b1;
                  emit_item.last       = !seen_ff;
                  hold_vld_in          = 1'b0;
                  if (!seen_ff) begin
                     state_in = S_IDLE;
                  end
               end else if (seen_ff) begin
                  emit_item.data       = term_ff;
                  emit_item.byte_valid = 1'b1;
                  seen_in              = 1'b0;
                  state_in             = S_IDLE;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Result register: loads on emit, clears when the transfer completes.
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_in       = emit_item;
         rsp_valid_in = 1'b1;
      end else if (out_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rd_idx_ff    <= '0;
         wr_idx_ff    <= '0;
         cnt_ff       <= '0;
         lim_ff       <= '0;
         n_ff         <= '0;
         hold_vld_ff  <= 1'b0;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_idx_ff    <= rd_idx_in;
         wr_idx_ff    <= wr_idx_in;
         cnt_ff       <= cnt_in;
         lim_ff       <= lim_in;
         n_ff         <= n_in;
         hold_vld_ff  <= hold_vld_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and per-command flags.
   always_ff @(posedge clock) begin
      full_ff     <= full_in;
      tn_ff       <= tn_in;
      is_pop_ff   <= is_pop_in;
      em_found_ff <= em_found_in;
      hold_ff     <= hold_in;
      term_ff     <= term_in;
      rsp_ff      <= rsp_in;
   end

   // Ring memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wr_idx_ff] <= cmd.data;
      end
      if (rd_en) begin
         rd_data_ff <= ring_mem[rd_idx_ff];
      end
   end

   `RRLB_ASSERT_ALWAYS(a_line_count_in_limit, clock, reset, n_ff <= lim_ff)
   `RRLB_ASSERT_IMPLY(a_push_leaves_data, clock, reset, (state_ff == S_PUSH) && !full_ff, wr_idx_ff != rd_idx_ff)
   `RRLB_ASSERT_IMPLY(a_idle_no_held_bytes, clock, reset, state_ff == S_IDLE, !seen_ff && !hold_vld_ff)

endmodule

// File: hw/rtl/rx_ring_line_buffer.sv
// ----------------------------------------------------------------------------
// rx_ring_line_buffer: receive byte ring with line reader
// Push, peek, pop, has-line and read-line over a byte ring that drops the
// oldest byte when a push fills it.
//
//   Channel  Direction  Payload
//   req_*    in         tdata: data_in, line_limit; tuser: func
//   rsp_*    out        tdata: data_out, line_found, dropped; tuser: byte_valid;
//                       tlast: last
//
// Push, peek, pop and has-line are answered from the engine state after idle;
// read line starts in S_LREQ, fetches each byte from the ring through S_LREQ
// and S_LDAT, due to the registered read port of the ring memory, and closes in S_LFIN.
// A two-entry command queue lets requests arrive while the engine works.
// Reset is synchronous and empties the ring at once; the memory is not cleared.
// A stalled result holds the engine in place; the queue keeps taking requests
// until it is full.
// ----------------------------------------------------------------------------
module rx_ring_line_buffer #(
   parameter int RING_DEPTH = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] data_in, [14:8] line_limit, [15] zero
   input  logic [2:0]  req_tuser,   // [2:0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] data_out, [8] line_found, [9] dropped,
                                    // [15:10] zero
   output logic [0:0]  rsp_tuser,   // [0] byte_valid
   output logic        rsp_tlast
);

   logic              fe_valid, fe_ready;
   rrlb_pkg::cmd_type fe_cmd;
   logic              q_valid, q_ready;
   rrlb_pkg::cmd_type q_cmd;
   rrlb_pkg::rsp_type rsp_item;

   // Front end: decode and clamp.
   rrlb_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (fe_valid),
      .cmd_ready  (fe_ready),
      .cmd        (fe_cmd)
   );

   // Command queue between front end and engine.
   rrlb_cmdq u_cmdq (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fe_valid),
      .push_ready (fe_ready),
      .push_cmd   (fe_cmd),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_cmd    (q_cmd)
   );

   // Ring engine with its result register.
   rrlb_engine #(
      .RING_DEPTH (RING_DEPTH)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_valid),
      .cmd_ready (q_ready),
      .cmd       (q_cmd),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (rsp_item)
   );

   // Result packing.
   assign rsp_tdata = {6'd0, rsp_item.dropped, rsp_item.line_found, rsp_item.data};
   assign rsp_tuser = rsp_item.byte_valid;
   assign rsp_tlast = rsp_item.last;

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the receive byte ring with line reader
// A short table of directed requests covers the empty ring, unused codes,
// terminator pairs and limit extremes. Random line traffic, noise, a drain of
// what is left and a quiet tail follow. Every response transfer is checked
// field by field against a behavioral copy of the ring or a typed answer.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int RING_DEPTH   = 512;
   localparam int LIMIT_CYCLES = 1_000_000;
   localparam int DRAIN_CYCLES = 150;
   localparam int HOLD_CYCLES  = 400;

   // Codes outside the defined set; the block must answer them like a no-op.
   localparam logic [2:0] FUNC_SPARE6 = 3'd6;
   localparam logic [2:0] FUNC_SPARE7 = 3'd7;

   // Single-result answers that can be typed in directly.
   localparam rrlb_pkg::rsp_type RSP_IDLE  = '{data: 8'h00, byte_valid: 1'b0,
                                               line_found: 1'b0, dropped: 1'b0,
                                               last: 1'b1};
   localparam rrlb_pkg::rsp_type RSP_FOUND = '{data: 8'h00, byte_valid: 1'b0,
                                               line_found: 1'b1, dropped: 1'b0,
                                               last: 1'b1};
   localparam rrlb_pkg::rsp_type RSP_ZERO  = '{data: 8'h00, byte_valid: 1'b1,
                                               line_found: 1'b0, dropped: 1'b0,
                                               last: 1'b1};

   // Endings appended to a random text line.
   typedef enum logic [2:0] {
      TAIL_NONE, TAIL_CR, TAIL_LF, TAIL_CRLF, TAIL_LFCR, TAIL_CRCR, TAIL_LFLF
   } tail_kind_type;

   typedef struct packed {
      logic [2:0]        func;
      logic [7:0]        data;
      logic [6:0]        lim;
      logic              typed;
      rrlb_pkg::rsp_type want;
   } stim_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = 16'h0000;   // [7:0] data_in, [14:8] line_limit, [15] zero
   logic [2:0]  req_tuser  = 3'd0;       // [2:0] func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;               // [7:0] data_out, [8] line_found, [9] dropped
   logic [0:0]  rsp_tuser;               // [0] byte_valid
   logic        rsp_tlast;

   // Behavioral copy of the ring.
   logic [7:0]  ring_mem [RING_DEPTH];
   int unsigned rd_ptr = 0;
   int unsigned wr_ptr = 0;

   rrlb_pkg::rsp_type step_q[$];
   rrlb_pkg::rsp_type rsp_expect_q[$];
   stim_row_type      stim_table[$];

   int          err_count      = 0;
   int          requests_sent  = 0;
   int          responses_seen = 0;
   int          lines_read     = 0;
   int          drops_seen     = 0;
   int          cycle_count    = 0;
   bit          quiet_mode     = 1'b0;
   bit          hold_request   = 1'b0;
   int          hold_left      = 0;
   int          stall_left     = 0;

   always #10 clock = ~clock;

   rx_ring_line_buffer #(
      .RING_DEPTH (RING_DEPTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   function automatic int unsigned wrap_inc(input int unsigned p);
      wrap_inc = (p + 1 == RING_DEPTH) ? 0 : p + 1;
   endfunction

   function automatic stim_row_type row(input logic [2:0] f, input logic [7:0] d,
                                        input logic [6:0] l, input logic typed,
                                        input rrlb_pkg::rsp_type want);
      row = '{func: f, data: d, lim: l, typed: typed, want: want};
   endfunction

   // Applies one request to the ring copy and leaves its responses in step_q.
   task automatic ring_apply(input logic [2:0] f, input logic [7:0] d, input logic [6:0] l);
      int unsigned       scan;
      int unsigned       cap;
      bit                term_seen;
      logic [7:0]        c;
      logic [7:0]        line_bytes[$];
      rrlb_pkg::rsp_type r;
      step_q.delete();
      r = RSP_IDLE;
      case (f)
         rrlb_pkg::FUNC_PUSH: begin
            ring_mem[wr_ptr] = d;
            wr_ptr = wrap_inc(wr_ptr);
            // A full ring gives up its oldest byte.
            if (wr_ptr == rd_ptr) begin
               rd_ptr = wrap_inc(rd_ptr);
               r.dropped = 1'b1;
               drops_seen++;
            end
            step_q.push_back(r);
         end
         rrlb_pkg::FUNC_PEEK, rrlb_pkg::FUNC_POP: begin
            if (rd_ptr != wr_ptr) begin
               r.data = ring_mem[rd_ptr];
               r.byte_valid = 1'b1;
               if (f == rrlb_pkg::FUNC_POP) rd_ptr = wrap_inc(rd_ptr);
            end
            step_q.push_back(r);
         end
         rrlb_pkg::FUNC_HAS_LINE: begin
            scan = rd_ptr;
            while (scan != wr_ptr) begin
               if (ring_mem[scan] == rrlb_pkg::CH_CR || ring_mem[scan] == rrlb_pkg::CH_LF) begin
                  r.line_found = 1'b1;
                  break;
               end
               scan = wrap_inc(scan);
            end
            step_q.push_back(r);
         end
         rrlb_pkg::FUNC_READ_LINE: begin
            cap = (l > rrlb_pkg::MAX_LINE) ? rrlb_pkg::MAX_LINE : l;
            scan = rd_ptr;
            term_seen = 1'b0;
            while (line_bytes.size() < cap && scan != wr_ptr) begin
               c = ring_mem[scan];
               if (c == rrlb_pkg::CH_CR || c == rrlb_pkg::CH_LF) begin
                  // A terminator pair is consumed and neither byte is returned.
                  if (term_seen) begin
                     scan = wrap_inc(scan);
                     void'(line_bytes.pop_back());
                     break;
                  end
                  term_seen = 1'b1;
               end else if (term_seen) begin
                  // The byte after a lone terminator stays in the ring.
                  break;
               end
               line_bytes.push_back(c);
               scan = wrap_inc(scan);
            end
            rd_ptr = scan;
            if (line_bytes.size() == 0) begin
               step_q.push_back(RSP_IDLE);
            end else begin
               lines_read++;
               foreach (line_bytes[k]) begin
                  r.data = line_bytes[k];
                  r.byte_valid = 1'b1;
                  r.last = (k == line_bytes.size() - 1);
                  step_q.push_back(r);
               end
            end
         end
         default: begin
            step_q.push_back(RSP_IDLE);
         end
      endcase
   endtask

   // Offers one request, waits for its transfer, then records what it should return.
   task automatic send_request(input logic [2:0] f, input logic [7:0] d, input logic [6:0] l,
                               input logic typed, input rrlb_pkg::rsp_type want);
      req_tvalid <= 1'b1;
      req_tuser  <= f;
      req_tdata  <= {1'b0, l, d};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      ring_apply(f, d, l);
      if (typed) begin
         rsp_expect_q.push_back(want);
      end else begin
         foreach (step_q[k]) rsp_expect_q.push_back(step_q[k]);
      end
      requests_sent++;
      // Random gaps on the sending side.
      if (!quiet_mode && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic push_byte(input logic [7:0] d);
      send_request(rrlb_pkg::FUNC_PUSH, d, 7'($urandom_range(0, 127)), 1'b0, RSP_IDLE);
   endtask

   task automatic random_noise();
      send_request(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                   7'($urandom_range(0, 127)), 1'b0, RSP_IDLE);
   endtask

   // Compares one response transfer with the oldest expectation.
   task automatic check_response();
      rrlb_pkg::rsp_type want;
      responses_seen++;
      if (rsp_expect_q.size() == 0) begin
         $error("unexpected response: data_out=%0h last=%0b", rsp_tdata[7:0], rsp_tlast);
         err_count++;
      end else begin
         want = rsp_expect_q.pop_front();
         if (rsp_tdata[7:0] !== want.data) begin
            $error("data_out: expected %0h, got %0h", want.data, rsp_tdata[7:0]);
            err_count++;
         end
         if (rsp_tuser[0] !== want.byte_valid) begin
            $error("byte_valid: expected %0b, got %0b", want.byte_valid, rsp_tuser[0]);
            err_count++;
         end
         if (rsp_tdata[8] !== want.line_found) begin
            $error("line_found: expected %0b, got %0b", want.line_found, rsp_tdata[8]);
            err_count++;
         end
         if (rsp_tdata[9] !== want.dropped) begin
            $error("dropped: expected %0b, got %0b", want.dropped, rsp_tdata[9]);
            err_count++;
         end
         if (rsp_tlast !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, rsp_tlast);
            err_count++;
         end
      end
   endtask

   // Response side: checks every transfer and drives ready with random stalls.
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) check_response();
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!quiet_mode && $urandom_range(0, 6) == 0) begin
            stall_left = $urandom_range(0, 3);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog on the whole run.
   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // Request side: directed table, random traffic, drain, quiet tail.
   initial begin
      logic [7:0]    txt;
      logic [6:0]    lim;
      tail_kind_type tail;
      bit            hold_done;
      bit            pause_done;
      hold_done  = 1'b0;
      pause_done = 1'b0;

      // Empty ring, unused codes, terminator pairs and limit extremes.
      stim_table.push_back(row(rrlb_pkg::FUNC_PEEK,      8'h00, 7'd0,   1'b1, RSP_IDLE));
      stim_table.push_back(row(rrlb_pkg::FUNC_POP,       8'hFF, 7'd127, 1'b1, RSP_IDLE));
      stim_table.push_back(row(rrlb_pkg::FUNC_HAS_LINE,  8'h00, 7'd0,   1'b1, RSP_IDLE));
      stim_table.push_back(row(rrlb_pkg::FUNC_READ_LINE, 8'h00, 7'd127, 1'b1, RSP_IDLE));
      stim_table.push_back(row(rrlb_pkg::FUNC_NOP,       8'h55, 7'd42,  1'b1, RSP_IDLE));
      stim_table.push_back(row(FUNC_SPARE6,              8'hAA, 7'd21,  1'b1, RSP_IDLE));
      stim_table.push_back(row(FUNC_SPARE7,              8'hFF, 7'd127, 1'b1, RSP_IDLE));
      stim_table.push_back(row(rrlb_pkg::FUNC_PUSH,      8'h00, 7'd0,   1'b1, RSP_IDLE));
      stim_table.push_back(row(rrlb_pkg::FUNC_PUSH,      8'hFF, 7'd127, 1'b1, RSP_IDLE));
      stim_table.push_back(row(rrlb_pkg::FUNC_PUSH, rrlb_pkg::CH_CR, 7'd0, 1'b1, RSP_IDLE));
      stim_table.push_back(row(rrlb_pkg::FUNC_PUSH,      8'h78, 7'd0,   1'b1, RSP_IDLE));
      stim_table.push_back(row(rrlb_pkg::FUNC_PEEK,      8'h00, 7'd0,   1'b1, RSP_ZERO));
      stim_table.push_back(row(rrlb_pkg::FUNC_HAS_LINE,  8'h00, 7'd0,   1'b1, RSP_FOUND));
      stim_table.push_back(row(rrlb_pkg::FUNC_READ_LINE, 8'h00, 7'd127, 1'b0, RSP_IDLE));
      stim_table.push_back(row(rrlb_pkg::FUNC_PUSH, rrlb_pkg::CH_LF, 7'd0, 1'b0, RSP_IDLE));
      stim_table.push_back(row(rrlb_pkg::FUNC_PUSH, rrlb_pkg::CH_CR, 7'd0, 1'b0, RSP_IDLE));
      stim_table.push_back(row(rrlb_pkg::FUNC_PUSH,      8'h79, 7'd0,   1'b0, RSP_IDLE));
      stim_table.push_back(row(rrlb_pkg::FUNC_READ_LINE, 8'h00, 7'd64,  1'b0, RSP_IDLE));
      stim_table.push_back(row(rrlb_pkg::FUNC_POP,       8'h00, 7'd0,   1'b0, RSP_IDLE));
      stim_table.push_back(row(rrlb_pkg::FUNC_PUSH, rrlb_pkg::CH_CR, 7'd0, 1'b0, RSP_IDLE));
      stim_table.push_back(row(rrlb_pkg::FUNC_PUSH, rrlb_pkg::CH_LF, 7'd0, 1'b0, RSP_IDLE));
      stim_table.push_back(row(rrlb_pkg::FUNC_READ_LINE, 8'h00, 7'd5,   1'b0, RSP_IDLE));
      stim_table.push_back(row(rrlb_pkg::FUNC_PUSH,      8'h7A, 7'd0,   1'b0, RSP_IDLE));
      stim_table.push_back(row(rrlb_pkg::FUNC_READ_LINE, 8'h00, 7'd0,   1'b1, RSP_IDLE));
      stim_table.push_back(row(rrlb_pkg::FUNC_POP,       8'h00, 7'd0,   1'b0, RSP_IDLE));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_table[i]) begin
         send_request(stim_table[i].func, stim_table[i].data, stim_table[i].lim,
                      stim_table[i].typed, stim_table[i].want);
      end

      // Random text lines with assorted endings, read back in pieces, plus noise.
      while (requests_sent < 205) begin
         if (!hold_done && requests_sent >= 100) begin
            // Long receiver hold-off while requests keep coming.
            hold_done = 1'b1;
            hold_request = 1'b1;
         end
         if (!pause_done && requests_sent >= 170) begin
            // Sender waits for every outstanding response.
            pause_done = 1'b1;
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (rsp_expect_q.size() != 0) @(posedge clock);
            @(posedge clock);
         end
         if ($urandom_range(0, 9) < 7) begin
            repeat ($urandom_range(0, 12)) begin
               if ($urandom_range(0, 7) == 0) begin
                  txt = 8'h00;
               end else begin
                  do txt = 8'($urandom_range(0, 255));
                  while (txt == rrlb_pkg::CH_CR || txt == rrlb_pkg::CH_LF);
               end
               push_byte(txt);
            end
            tail = tail_kind_type'($urandom_range(0, 6));
            case (tail)
               TAIL_CR:   push_byte(rrlb_pkg::CH_CR);
               TAIL_LF:   push_byte(rrlb_pkg::CH_LF);
               TAIL_CRLF: begin push_byte(rrlb_pkg::CH_CR); push_byte(rrlb_pkg::CH_LF); end
               TAIL_LFCR: begin push_byte(rrlb_pkg::CH_LF); push_byte(rrlb_pkg::CH_CR); end
               TAIL_CRCR: begin push_byte(rrlb_pkg::CH_CR); push_byte(rrlb_pkg::CH_CR); end
               TAIL_LFLF: begin push_byte(rrlb_pkg::CH_LF); push_byte(rrlb_pkg::CH_LF); end
               default:   ;
            endcase
            if ($urandom_range(0, 1) == 0) begin
               send_request(rrlb_pkg::FUNC_HAS_LINE, 8'h00, 7'd0, 1'b0, RSP_IDLE);
            end
            case ($urandom_range(0, 9))
               0:       lim = 7'd0;
               1:       lim = 7'($urandom_range(65, 127));
               2:       lim = 7'd64;
               default: lim = 7'($urandom_range(1, 16));
            endcase
            send_request(rrlb_pkg::FUNC_READ_LINE, 8'($urandom_range(0, 255)), lim,
                         1'b0, RSP_IDLE);
            if ($urandom_range(0, 3) == 0) begin
               send_request(($urandom_range(0, 1) == 0) ? rrlb_pkg::FUNC_PEEK
                                                        : rrlb_pkg::FUNC_POP,
                            8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                            1'b0, RSP_IDLE);
            end
         end else begin
            random_noise();
         end
      end

      // Drain what is left in the ring.
      send_request(rrlb_pkg::FUNC_HAS_LINE, 8'h00, 7'd0, 1'b0, RSP_IDLE);
      repeat (10) send_request(rrlb_pkg::FUNC_READ_LINE, 8'h00, 7'd127, 1'b0, RSP_IDLE);
      send_request(rrlb_pkg::FUNC_PEEK, 8'h00, 7'd0, 1'b0, RSP_IDLE);
      send_request(rrlb_pkg::FUNC_POP, 8'h00, 7'd0, 1'b0, RSP_IDLE);

      // Quiet tail: no gaps and no stalls on either side.
      quiet_mode = 1'b1;
      repeat (40) random_noise();
      req_tvalid <= 1'b0;

      while (rsp_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d requests and %0d checked response transfers,",
               requests_sent, responses_seen);
      $display("with %0d non-empty line reads and %0d overwrite drops.",
               lines_read, drops_seen);
      if (err_count == 0 && rsp_expect_q.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
